/* hdl/d8_inflow_neighbour_mask_macros.svh */
`ifndef D8_INFLOW_NEIGHBOUR_MASK_MACROS_SVH
`define D8_INFLOW_NEIGHBOUR_MASK_MACROS_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define D8IM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define D8IM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/d8im_pkg.sv */
package d8im_pkg;

	localparam int unsigned ROW_W    = 16;
	localparam int unsigned OUT_COL_W = 12;
	localparam int unsigned CODE_W   = 8;
	localparam int unsigned CCOUNT_W = 13;
	localparam int unsigned CFG_W    = 16;

	localparam logic [CCOUNT_W-1:0] COLUMN_COUNT_RESET = 13'd1024;
	localparam logic [ROW_W-1:0]    ROW_COUNT_RESET    = 16'd1024;

	typedef enum logic [0:0] {
		REG_COLUMN_COUNT = 1'b0,
		REG_ROW_COUNT    = 1'b1
	} reg_index_t;

	// Codes that point a neighbor at the center cell.
	localparam logic [CODE_W-1:0] CODE_FROM_LOWER_LEFT  = 8'd9;
	localparam logic [CODE_W-1:0] CODE_FROM_BELOW       = 8'd8;
	localparam logic [CODE_W-1:0] CODE_FROM_LOWER_RIGHT = 8'd7;
	localparam logic [CODE_W-1:0] CODE_FROM_LEFT        = 8'd6;
	localparam logic [CODE_W-1:0] CODE_FROM_RIGHT       = 8'd4;
	localparam logic [CODE_W-1:0] CODE_FROM_UPPER_LEFT  = 8'd3;
	localparam logic [CODE_W-1:0] CODE_FROM_ABOVE       = 8'd2;
	localparam logic [CODE_W-1:0] CODE_FROM_UPPER_RIGHT = 8'd1;

	localparam int unsigned OUT_DEPTH = 3;
	localparam int unsigned OUT_PTR_W = 2;

	typedef struct packed {
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
		logic [7:0]           mask;
		logic                 last;
	} result_t;

endpackage

/* hdl/d8_inflow_neighbour_mask.sv */
// Streams a raster of D8 drain codes, one cell per item in row order, and emits
// for each interior cell the mask of neighbors that drain into it. One cell is
// taken every clock cycle while code_stall is low; the result for cell (r-1, c-1)
// follows the taking of cell (r, c). The two line stores are read at the accepting
// edge, the window and mask are formed in the next cycle and written into the
// output queue, and the queue presents the result from the cycle after that.
// A three-entry output queue absorbs the items still in flight, so the input
// stalls only when the output side stalls.
// A write to either register restarts the frame at row 0, column 0.
module d8_inflow_neighbour_mask
	import d8im_pkg::*;
#(
	parameter int unsigned MAX_COLS = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  code_valid,
	output logic                  code_stall,
	input  logic [CODE_W-1:0]     direction_code,
	output logic                  cell_valid,
	input  logic                  cell_stall,
	output logic [ROW_W-1:0]      cell_row,
	output logic [OUT_COL_W-1:0]  cell_col,
	output logic [7:0]            inflow_mask,
	output logic                  last_cell
);

	localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int unsigned CNT_W = (COL_W + 1 > CCOUNT_W) ? COL_W + 1 : CCOUNT_W;

	logic [CCOUNT_W-1:0] column_count_q;
	logic [ROW_W-1:0]    row_count_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;

	logic [CNT_W-1:0] cols_eff;
	logic [CNT_W-1:0] cnt_ext;
	logic [CNT_W-1:0] col_ext;
	logic [CNT_W-1:0] col_m1;
	logic [ROW_W-1:0] rows_eff;
	logic             col_last;
	logic             row_last;
	logic             accept;

	logic [CODE_W-1:0] line_older_q [MAX_COLS];
	logic [CODE_W-1:0] line_newer_q [MAX_COLS];

	logic              acc_s1;
	logic              emit_s1;
	logic              last_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [OUT_COL_W-1:0] col_s1;
	logic [COL_W-1:0]  addr_s1;
	logic [CODE_W-1:0] bot_s1;
	logic [CODE_W-1:0] mid_s1;
	logic [CODE_W-1:0] top_s1;

	logic [CODE_W-1:0] win_q [6];
	logic [7:0]        mask;
	logic              push;
	logic              pop;

	result_t              fifo_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_PTR_W-1:0] cnt_q;
	result_t              head;

	always_comb begin
		cnt_ext = CNT_W'(column_count_q);
		if (column_count_q == '0) begin
			cols_eff = CNT_W'(1);
		end else if (cnt_ext > CNT_W'(MAX_COLS)) begin
			cols_eff = CNT_W'(MAX_COLS);
		end else begin
			cols_eff = cnt_ext;
		end
		rows_eff = (row_count_q == '0) ? ROW_W'(1) : row_count_q;
		col_ext  = CNT_W'(col_q);
		col_m1   = col_ext - CNT_W'(1);
		col_last = (col_ext == cols_eff - CNT_W'(1));
		row_last = (row_q == rows_eff - ROW_W'(1));
	end

	assign code_stall = ({1'b0, cnt_q} + {2'b00, acc_s1}) >= 3'(OUT_DEPTH);
	assign accept     = code_valid && !code_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= COLUMN_COUNT_RESET;
			row_count_q    <= ROW_COUNT_RESET;
			row_q          <= '0;
			col_q          <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLUMN_COUNT: column_count_q <= cfg_data[CCOUNT_W-1:0];
				REG_ROW_COUNT:    row_count_q    <= cfg_data[ROW_W-1:0];
			endcase
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// The row just above: read and rewritten at the same column on the same edge.
	always_ff @(posedge clk) begin
		if (accept) begin
			mid_s1              <= line_newer_q[col_q];
			line_newer_q[col_q] <= direction_code;
		end
	end

	// Two rows above: read on accept, refilled in the following cycle from the row above.
	always_ff @(posedge clk) begin
		if (accept) begin
			top_s1 <= line_older_q[col_q];
		end
		if (acc_s1) begin
			line_older_q[addr_s1] <= mid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0;
		end else begin
			acc_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bot_s1  <= direction_code;
			addr_s1 <= col_q;
			emit_s1 <= (row_q >= ROW_W'(2)) && (col_ext >= CNT_W'(2));
			last_s1 <= col_last && row_last;
			row_s1  <= row_q - ROW_W'(1);
			col_s1  <= col_m1[OUT_COL_W-1:0];
		end
	end

	always_comb begin
		mask[0] = (win_q[2] == CODE_FROM_LOWER_LEFT);
		mask[1] = (win_q[5] == CODE_FROM_BELOW);
		mask[2] = (bot_s1   == CODE_FROM_LOWER_RIGHT);
		mask[3] = (win_q[1] == CODE_FROM_LEFT);
		mask[4] = (mid_s1   == CODE_FROM_RIGHT);
		mask[5] = (win_q[0] == CODE_FROM_UPPER_LEFT);
		mask[6] = (win_q[3] == CODE_FROM_ABOVE);
		mask[7] = (top_s1   == CODE_FROM_UPPER_RIGHT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (acc_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= bot_s1;
		end
	end

	assign push = acc_s1 && emit_s1;
	assign pop  = cell_valid && !cell_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{row: row_s1, col: col_s1, mask: mask, last: last_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
					: wr_ptr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
					: rd_ptr_q + OUT_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + OUT_PTR_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - OUT_PTR_W'(1);
			end
		end
	end

	assign head        = fifo_q[rd_ptr_q];
	assign cell_valid  = (cnt_q != '0);
	assign cell_row    = head.row;
	assign cell_col    = head.col;
	assign inflow_mask = head.mask;
	assign last_cell   = head.last;

`include "d8_inflow_neighbour_mask_macros.svh"

	`D8IM_ASSERT_NOW(a_no_overflow, push, cnt_q != OUT_PTR_W'(OUT_DEPTH), "queue overflow")
	`D8IM_ASSERT_NOW(a_interior, cell_valid, (cell_row != '0) && (cell_col != '0), "border cell emitted")
	`D8IM_ASSERT_NEXT(a_cfg_restart, cfg_we, (row_q == '0) && (col_q == '0), "frame not restarted")

endmodule
